// ===== src/css_pkg.sv =====
// Shared types, codes and helpers for the caseless substring search core.
`timescale 1ns / 1ps

package css_pkg;

   localparam int BYTE_W  = 8;
   localparam int MODE_W  = 2;
   localparam int INDEX_W = 16;
   localparam int STAT_W  = 2;
   localparam int RSP_W   = 24;

   localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_END     = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_PAT_LONG  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_TEXT_LONG = 2'd2;

   typedef struct packed {
      logic pat_shift;
      logic txt_shift;
      logic clear;
   } css_ctl_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [INDEX_W-1:0] match_index;
      logic               found;
   } css_rsp_type;

   function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5a) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

endpackage

// ===== src/css_cell.sv =====
// One search cell: a pattern byte and a text byte, each shifted from the neighbor.
`timescale 1ns / 1ps

module css_cell
   import css_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  css_ctl_type       ctl,
   input  logic [BYTE_W-1:0] pat_in,
   input  logic              pat_v_in,
   input  logic [BYTE_W-1:0] txt_in,
   input  logic              txt_v_in,
   output logic [BYTE_W-1:0] pat_out,
   output logic              pat_v_out,
   output logic [BYTE_W-1:0] txt_out,
   output logic              txt_v_out,
   output logic              ok
);

   logic [BYTE_W-1:0] pat_ff;
   logic              pat_v_ff;
   logic [BYTE_W-1:0] txt_ff;
   logic              txt_v_ff;

   always_ff @(posedge clock) begin
      if (ctl.pat_shift) begin
         pat_ff <= pat_in;
      end
      if (ctl.txt_shift) begin
         txt_ff <= txt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         pat_v_ff <= 1'b0;
         txt_v_ff <= 1'b0;
      end else begin
         if (ctl.pat_shift) begin
            pat_v_ff <= pat_v_in;
         end
         if (ctl.txt_shift) begin
            txt_v_ff <= txt_v_in;
         end
      end
   end

   // compare the byte about to enter against the stored pattern byte
   assign ok        = !pat_v_ff || (txt_v_in && (txt_in == pat_ff));
   assign pat_out   = pat_ff;
   assign pat_v_out = pat_v_ff;
   assign txt_out   = txt_ff;
   assign txt_v_out = txt_v_ff;

endmodule

// ===== src/css_rsp_buf.sv =====
// Result register with a skid stage on the result channel.
`timescale 1ns / 1ps

module css_rsp_buf
   import css_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  css_rsp_type push_data,
   output logic        room,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output css_rsp_type rsp_data
);

   css_rsp_type out_ff;
   logic        out_v_ff;
   css_rsp_type skid_ff;
   logic        skid_v_ff;
   logic        pop;

   assign pop = out_v_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            out_ff    <= skid_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            out_ff   <= push_data;
            out_v_ff <= 1'b1;
         end else begin
            skid_ff   <= push_data;
            skid_v_ff <= 1'b1;
         end
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end

   assign room       = !skid_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_data   = out_ff;

`ifndef ASSERT_OFF
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid stage holds data while output register is empty");
   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && rsp_tready) |=> (out_v_ff && !skid_v_ff))
      else $error("skid stage did not advance on transfer");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !rsp_tready) |=> skid_v_ff)
      else $error("skid stage dropped a result");
`endif

endmodule

// ===== src/caseless_substring_search_core.sv =====
// Top level of the caseless substring search core: cell row, counters and result path.
//
//   channel | dir | tdata                          | tuser
//   req     | in  | data_byte[7:0]                 | mode[1:0]
//   rsp     | out | found, match_index, status     | -
//
// One item per cycle on req while req_tready is high; every item finishes in the cycle it is accepted.
// A result is registered into the output register, or into the skid stage while that register holds an untaken result.
// req_tready drops only while both result register and skid stage are full.
// Reset clears all valid bits and counters; no clearing pass is needed.
`timescale 1ns / 1ps

module caseless_substring_search_core
   import css_pkg::*;
#(
   parameter int MAX_PATTERN = 32,
   parameter int MAX_TEXT    = 65535
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // data_byte[7:0]
   input  logic [MODE_W-1:0] req_tuser,   // mode[1:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata    // found[0], match_index[16:1], status[18:17], zeros
);

   localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
   localparam int TPOS_W = $clog2(MAX_TEXT + 1);
   localparam int SUB_W  = (CNT_W > TPOS_W) ? CNT_W : TPOS_W;

   logic [CNT_W-1:0]   count_ff;
   logic [TPOS_W-1:0]  tpos_ff;
   logic [TPOS_W-1:0]  tpos_in;
   logic               seen_ff;
   logic [INDEX_W-1:0] first_ff;
   logic [STAT_W-1:0]  err_ff;

   logic               acc;
   logic               is_pat;
   logic               is_txt;
   logic               is_end;
   logic               pat_full;
   logic               txt_full;
   logic [BYTE_W-1:0]  byte_f;
   css_ctl_type        ctl;
   logic               all_ok;
   logic               hit;
   logic [SUB_W-1:0]   diff;
   css_rsp_type        result;
   css_rsp_type        rsp_data;
   logic               room;

   logic [BYTE_W-1:0]      pat_q [MAX_PATTERN+1];
   logic                   pat_v [MAX_PATTERN+1];
   logic [BYTE_W-1:0]      txt_q [MAX_PATTERN+1];
   logic                   txt_v [MAX_PATTERN+1];
   logic [MAX_PATTERN-1:0] ok;

   assign acc      = req_tvalid && req_tready;
   assign is_pat   = acc && (req_tuser == MODE_PATTERN);
   assign is_txt   = acc && (req_tuser == MODE_TEXT);
   assign is_end   = acc && (req_tuser == MODE_END);
   assign pat_full = (count_ff == CNT_W'(MAX_PATTERN));
   assign txt_full = (tpos_ff == TPOS_W'(MAX_TEXT));
   assign byte_f   = fold(req_tdata);
   assign tpos_in  = tpos_ff + 1'b1;

   assign ctl.pat_shift = is_pat && !pat_full;
   assign ctl.txt_shift = is_txt && !txt_full;
   assign ctl.clear     = is_end;

   assign pat_q[0] = byte_f;
   assign pat_v[0] = 1'b1;
   assign txt_q[0] = byte_f;
   assign txt_v[0] = 1'b1;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      css_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .pat_in    (pat_q[i]),
         .pat_v_in  (pat_v[i]),
         .txt_in    (txt_q[i]),
         .txt_v_in  (txt_v[i]),
         .pat_out   (pat_q[i+1]),
         .pat_v_out (pat_v[i+1]),
         .txt_out   (txt_q[i+1]),
         .txt_v_out (txt_v[i+1]),
         .ok        (ok[i])
      );
   end

   assign all_ok = &ok;
   assign hit    = ctl.txt_shift && !seen_ff && pat_v[1] && all_ok;
   assign diff   = SUB_W'(tpos_in) - SUB_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         count_ff <= '0;
         tpos_ff  <= '0;
         seen_ff  <= 1'b0;
         first_ff <= '0;
         err_ff   <= STAT_OK;
      end else begin
         if (ctl.pat_shift) begin
            count_ff <= count_ff + 1'b1;
         end
         if (ctl.txt_shift) begin
            tpos_ff <= tpos_in;
         end
         if (hit) begin
            seen_ff  <= 1'b1;
            first_ff <= INDEX_W'(diff);
         end
         if (err_ff == STAT_OK) begin
            if (is_pat && pat_full) begin
               err_ff <= STAT_PAT_LONG;
            end else if (is_txt && txt_full) begin
               err_ff <= STAT_TEXT_LONG;
            end
         end
      end
   end

   always_comb begin
      result.status      = err_ff;
      result.found       = 1'b0;
      result.match_index = '0;
      if (err_ff == STAT_OK) begin
         if (count_ff == '0) begin
            result.found = 1'b1;
         end else if (seen_ff) begin
            result.found       = 1'b1;
            result.match_index = first_ff;
         end
      end
   end

   css_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (is_end),
      .push_data  (result),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign req_tready = room;
   assign rsp_tdata  = {{(RSP_W - STAT_W - INDEX_W - 1){1'b0}}, rsp_data};

`ifndef ASSERT_OFF
   a_seen_needs_pattern: assert property (@(posedge clock) disable iff (reset)
      seen_ff |-> (count_ff != '0))
      else $error("match recorded with empty pattern");
   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      ((err_ff != STAT_OK) && !is_end) |=> (err_ff == $past(err_ff)))
      else $error("error status changed before result");
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      is_end |=> ((count_ff == '0) && (tpos_ff == '0) && !seen_ff))
      else $error("search state not cleared after result");
   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty result path");
`endif

endmodule

// ===== sim/caseless_substring_search_core_test.sv =====
// Stream test of the caseless substring search core against a built-in search predictor.
`timescale 1ns / 1ps

module caseless_substring_search_core_test;
   import css_pkg::*;

   localparam int PAT_DEPTH  = 32;
   localparam int TEXT_LIMIT = 65535;
   localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [BYTE_W-1:0]  req_tdata;   // data_byte[7:0]
   logic [MODE_W-1:0]  req_tuser;   // mode[1:0]
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;   // found[0], match_index[16:1], status[18:17], zeros

   int send_idle_pct;
   int recv_idle_pct;
   int fail_count;
   int items_sent;

   css_rsp_type search_results[$];
   css_rsp_type seen_rsp;
   css_rsp_type want_rsp;

   logic [BYTE_W-1:0]  pat_mem[PAT_DEPTH];
   logic [BYTE_W-1:0]  win_mem[PAT_DEPTH];
   int unsigned        pat_len;
   int unsigned        text_len;
   logic               hit_flag;
   logic [INDEX_W-1:0] hit_start;
   logic [STAT_W-1:0]  err_code;

   caseless_substring_search_core #(
      .MAX_PATTERN(PAT_DEPTH),
      .MAX_TEXT   (TEXT_LIMIT)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic logic [BYTE_W-1:0] lower_case(input logic [BYTE_W-1:0] b);
      if (b >= 8'h41 && b <= 8'h5a) begin
         return b + 8'h20;
      end
      return b;
   endfunction

   function automatic void clear_search();
      for (int i = 0; i < PAT_DEPTH; i++) begin
         pat_mem[i] = '0;
         win_mem[i] = '0;
      end
      pat_len   = 0;
      text_len  = 0;
      hit_flag  = 1'b0;
      hit_start = '0;
      err_code  = STAT_OK;
   endfunction

   function automatic void load_pattern_byte(input logic [BYTE_W-1:0] b);
      if (pat_len >= PAT_DEPTH) begin
         if (err_code == STAT_OK) err_code = STAT_PAT_LONG;
      end else begin
         pat_mem[pat_len] = b;
         pat_len++;
      end
   endfunction

   function automatic void scan_text_byte(input logic [BYTE_W-1:0] b);
      logic hit;
      if (text_len >= TEXT_LIMIT) begin
         if (err_code == STAT_OK) err_code = STAT_TEXT_LONG;
      end else begin
         for (int k = PAT_DEPTH - 1; k > 0; k--) win_mem[k] = win_mem[k-1];
         win_mem[0] = b;
         text_len++;
         if (!hit_flag && pat_len != 0 && text_len >= pat_len) begin
            hit = 1'b1;
            for (int k = 0; k < pat_len; k++) begin
               if (win_mem[pat_len-1-k] != pat_mem[k]) hit = 1'b0;
            end
            if (hit) begin
               hit_flag  = 1'b1;
               hit_start = INDEX_W'(text_len - pat_len);
            end
         end
      end
   endfunction

   function automatic void close_search();
      css_rsp_type r;
      r.found       = 1'b0;
      r.match_index = '0;
      r.status      = err_code;
      if (err_code == STAT_OK) begin
         if (pat_len == 0) begin
            r.found = 1'b1;
         end else if (hit_flag) begin
            r.found       = 1'b1;
            r.match_index = hit_start;
         end
      end
      search_results.push_back(r);
      clear_search();
   endfunction

   function automatic void predict_search(input logic [MODE_W-1:0] mode,
                                          input logic [BYTE_W-1:0] b);
      case (mode)
         MODE_PATTERN: load_pattern_byte(lower_case(b));
         MODE_TEXT:    scan_text_byte(lower_case(b));
         MODE_END:     close_search();
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predict_search(mode, b);
      if (mode != MODE_IGNORED) items_sent++;
   endtask

   task automatic send_string(input logic [MODE_W-1:0] mode, input string s);
      for (int i = 0; i < s.len(); i++) send_item(mode, s[i]);
   endtask

   task automatic finish_search();
      send_item(MODE_END, BYTE_W'($urandom_range(255)));
   endtask

   function automatic logic [BYTE_W-1:0] random_char();
      case ($urandom_range(9))
         0, 1: return "a";
         2, 3: return "A";
         4:    return "b";
         5:    return "B";
         6:    return "c";
         default: return BYTE_W'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] flip_case(input logic [BYTE_W-1:0] b);
      if (((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a)) && $urandom_range(1))
         return b ^ 8'h20;
      return b;
   endfunction

   // transfer checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp = css_rsp_type'(rsp_tdata[$bits(css_rsp_type)-1:0]);
         if (search_results.size() == 0) begin
            report_mismatch("unexpected result", 32'(seen_rsp), 0);
         end else begin
            want_rsp = search_results.pop_front();
            if (seen_rsp.found != want_rsp.found)
               report_mismatch("found", 32'(seen_rsp.found), 32'(want_rsp.found));
            if (seen_rsp.match_index != want_rsp.match_index)
               report_mismatch("match_index", 32'(seen_rsp.match_index),
                               32'(want_rsp.match_index));
            if (seen_rsp.status != want_rsp.status)
               report_mismatch("status", 32'(seen_rsp.status), 32'(want_rsp.status));
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic test_empty_pattern();
      finish_search();
      send_string(MODE_TEXT, "zz");
      finish_search();
   endtask

   task automatic test_case_folding();
      send_string(MODE_PATTERN, "AbZ");
      send_string(MODE_TEXT, "@aBz");
      finish_search();
      send_string(MODE_PATTERN, "@[");
      send_string(MODE_TEXT, "`{");
      finish_search();
      send_item(MODE_PATTERN, 8'hff);
      send_item(MODE_PATTERN, 8'h00);
      send_item(MODE_TEXT, 8'h00);
      send_item(MODE_TEXT, 8'hff);
      send_item(MODE_TEXT, 8'h00);
      finish_search();
   endtask

   task automatic test_pattern_longer_than_text();
      send_string(MODE_PATTERN, "abc");
      send_string(MODE_TEXT, "AB");
      finish_search();
   endtask

   task automatic test_late_pattern();
      send_string(MODE_PATTERN, "b");
      send_string(MODE_TEXT, "xB");
      send_string(MODE_PATTERN, "c");
      send_string(MODE_TEXT, "bc");
      finish_search();
      send_string(MODE_PATTERN, "q");
      send_string(MODE_TEXT, "zz");
      send_string(MODE_PATTERN, "R");
      send_string(MODE_TEXT, "qr");
      finish_search();
   endtask

   task automatic test_ignored_mode();
      send_string(MODE_PATTERN, "k");
      send_item(MODE_IGNORED, 8'hff);
      send_string(MODE_TEXT, "aK");
      send_item(MODE_IGNORED, 8'h00);
      finish_search();
   endtask

   task automatic test_pattern_limits();
      for (int i = 0; i < PAT_DEPTH; i++) send_item(MODE_PATTERN, 8'h41 + BYTE_W'(i % 26));
      send_string(MODE_TEXT, "zz");
      for (int i = 0; i < PAT_DEPTH; i++) send_item(MODE_TEXT, 8'h61 + BYTE_W'(i % 26));
      finish_search();
      for (int i = 0; i <= PAT_DEPTH; i++) send_item(MODE_PATTERN, "x");
      send_string(MODE_TEXT, "x");
      finish_search();
   endtask

   task automatic test_random_searches(input int target);
      int stop_at;
      int kind;
      int plen;
      logic [BYTE_W-1:0] pat[$];
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         kind = $urandom_range(99);
         if (kind < 80) begin
            pat.delete();
            plen = ($urandom_range(11) == 0) ? $urandom_range(PAT_DEPTH + 2) : $urandom_range(5);
            repeat (plen) begin
               pat.push_back(random_char());
               send_item(MODE_PATTERN, pat[$]);
            end
            repeat ($urandom_range(12)) begin
               case ($urandom_range(19))
                  0:       send_item(MODE_IGNORED, BYTE_W'($urandom_range(255)));
                  1:       send_item(MODE_PATTERN, random_char());
                  default: send_item(MODE_TEXT, random_char());
               endcase
            end
            if ($urandom_range(1)) begin
               foreach (pat[i]) send_item(MODE_TEXT, flip_case(pat[i]));
            end
            repeat ($urandom_range(12)) send_item(MODE_TEXT, random_char());
            finish_search();
         end else if (kind < 90) begin
            repeat ($urandom_range(1, 8))
               send_item(MODE_W'($urandom_range(3)), BYTE_W'($urandom_range(255)));
            finish_search();
         end else begin
            repeat ($urandom_range(2, 6)) finish_search();
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = MODE_PATTERN;
      fail_count    = 0;
      items_sent    = 0;
      send_idle_pct = 36;
      recv_idle_pct = 73;
      clear_search();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_pattern();
      test_case_folding();
      test_pattern_longer_than_text();
      test_late_pattern();
      test_ignored_mode();
      test_pattern_limits();
      test_random_searches(220);

      send_idle_pct = 73;
      recv_idle_pct = 36;
      test_random_searches(220);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_searches(220);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (search_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/css_pkg.sv
src/css_cell.sv
src/css_rsp_buf.sv
src/caseless_substring_search_core.sv
sim/caseless_substring_search_core_test.sv
